FILE: hw/rtl/msas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msas_pkg
// Types and constants of the multi-slot alarm scheduler.
// ----------------------------------------------------------------------------
package msas_pkg;

  localparam int unsigned Slots = 8;
  localparam int unsigned SlotW = 3;

  localparam logic [31:0] RecentSeconds = 32'd45;
  localparam logic [31:0] ExpireSeconds = 32'd60;
  localparam logic [31:0] DaySeconds    = 32'd86400;

  localparam logic [2:0] ActTick   = 3'd0;
  localparam logic [2:0] ActAdd    = 3'd1;
  localparam logic [2:0] ActStop   = 3'd2;
  localparam logic [2:0] ActDelete = 3'd3;
  localparam logic [2:0] ActSnooze = 3'd4;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StFull    = 3'd1;
  localparam logic [2:0] StNoRing  = 3'd2;
  localparam logic [2:0] StEmpty   = 3'd3;
  localparam logic [2:0] StRang    = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  slot;
    logic [31:0] now_seconds;
    logic [4:0]  now_hour;
    logic [5:0]  now_minute;
    logic [5:0]  now_second;
    logic [4:0]  alarm_hour;
    logic [5:0]  alarm_minute;
    logic        repeat_daily;
    logic [4:0]  snooze_minutes;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       ringing;
    logic [2:0] ring_slot;
    logic [2:0] added_slot;
    logic [3:0] enabled_count;
    logic [3:0] used_count;
  } rsp_t;

endpackage
`default_nettype wire

FILE: hw/rtl/multi_slot_alarm_scheduler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_slot_alarm_scheduler_unit
// Eight-slot alarm engine with daily, one-time and snooze alarms.
// ----------------------------------------------------------------------------
// One request at a time, through one shared 34-bit adder. A tick runs an
// expiry pass over all eight slots, then a ring scan, one slot per cycle,
// a finish state that applies the action, and the result state. The scan
// stops at the first slot that fires, and it is skipped while an alarm
// rings. Add and toggle run three timestamp steps, finish and result. Stop,
// delete, snooze and unknown actions go straight to finish and result.
// in_ready_o is low while a request is in work or a result waits on the
// output.
module multi_slot_alarm_scheduler_unit
  import msas_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rsp_t      out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXP, S_SCAN, S_TS0, S_TS1, S_TS2, S_FIN, S_OUT
  } state_e;

  state_e      state_q;
  req_t        req_q;
  logic [SlotW-1:0] idx_q;
  logic [Slots-1:0] used_q, en_q, rep_q, ring_q;
  logic [4:0]  hour_q [Slots];
  logic [5:0]  min_q  [Slots];
  logic [4:0]  snz_q  [Slots];
  logic [31:0] due_q  [Slots];
  logic [31:0] until_q[Slots];
  logic [31:0] last_q [Slots];
  logic        act_v_q;
  logic [SlotW-1:0] act_s_q;
  logic        fired_q;
  logic [SlotW-1:0] fire_s_q;
  logic [33:0] acc_q;
  logic [31:0] ts_q;
  logic [2:0]  status_q;
  logic [SlotW-1:0] added_q;

  function automatic logic [31:0] sat34(input logic [33:0] v);
    if (v[33]) return 32'd0;
    if (v[32]) return 32'hFFFF_FFFF;
    return v[31:0];
  endfunction

  // shared adder
  logic [33:0] add_a, add_b, add_y;
  assign add_y = add_a + add_b;

  logic [16:0] day_sec, hm_sec;
  logic [4:0]  ts_h;
  logic [5:0]  ts_m;
  logic [SlotW-1:0] sl;
  assign sl = req_q.slot;
  assign ts_h = (req_q.action == ActAdd) ? req_q.alarm_hour : hour_q[sl];
  assign ts_m = (req_q.action == ActAdd) ? req_q.alarm_minute : min_q[sl];
  assign day_sec = 17'(req_q.now_hour) * 17'd3600 + 17'(req_q.now_minute) * 17'd60
                 + 17'(req_q.now_second);
  assign hm_sec  = 17'(ts_h) * 17'd3600 + 17'(ts_m) * 17'd60;

  logic [SlotW-1:0] free_s;
  logic             free_v;
  always_comb begin
    free_s = '0;
    free_v = 1'b0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_s = SlotW'(i);
        free_v = 1'b1;
      end
    end
  end

  // per-state operand selection
  logic [31:0] now;
  assign now = req_q.now_seconds;
  always_comb begin
    add_a = 34'(now);
    add_b = '0;
    unique case (state_q)
      S_EXP:  begin add_a = 34'(due_q[idx_q]); add_b = 34'(ExpireSeconds); end
      S_SCAN: begin add_a = 34'(last_q[idx_q]); add_b = 34'(RecentSeconds); end
      S_TS0:  begin add_b = ~34'(day_sec) + 34'd1; end
      S_TS1:  begin add_a = acc_q; add_b = 34'(hm_sec); end
      S_TS2:  begin add_a = acc_q; add_b = 34'(DaySeconds); end
      S_FIN:  begin add_b = 34'(snz_q[act_s_q]) * 34'd60; end
      default: ;
    endcase
  end

  logic [3:0] cnt_u, cnt_e;
  always_comb begin
    cnt_u = '0;
    cnt_e = '0;
    for (int i = 0; i < Slots; i++) begin
      cnt_u = cnt_u + 4'(used_q[i]);
      cnt_e = cnt_e + 4'(used_q[i] & en_q[i]);
    end
  end

  logic act_rings;
  assign act_rings = act_v_q && used_q[act_s_q] && ring_q[act_s_q];

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  logic recent, lt;
  assign recent = (last_q[idx_q] != '0) && (34'(now) < add_y);
  assign lt     = now < until_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q   <= '0;
      idx_q   <= '0;
      used_q  <= '0;
      en_q    <= '0;
      rep_q   <= '0;
      ring_q  <= '0;
      act_v_q <= 1'b0;
      act_s_q <= '0;
      fired_q <= 1'b0;
      fire_s_q <= '0;
      acc_q   <= '0;
      ts_q    <= '0;
      status_q <= StOk;
      added_q <= '0;
      for (int i = 0; i < Slots; i++) begin
        hour_q[i] <= '0; min_q[i] <= '0; snz_q[i] <= '0;
        due_q[i] <= '0; until_q[i] <= '0; last_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q   <= in_data_i;
            idx_q   <= '0;
            fired_q <= 1'b0;
            if (in_data_i.action == ActTick) begin
              state_q <= S_EXP;
            end else if (in_data_i.action == ActAdd ||
                         (in_data_i.action == ActStop &&
                          !(act_v_q && ring_q[act_s_q]))) begin
              state_q <= S_TS0;
            end else begin
              state_q <= S_FIN;
            end
          end
        end
        S_EXP: begin
          // disable one-time alarms well past their time
          if (used_q[idx_q] && en_q[idx_q] && !rep_q[idx_q] && until_q[idx_q] == '0 &&
              due_q[idx_q] != '0 && 34'(now) > add_y && !ring_q[idx_q])
            en_q[idx_q] <= 1'b0;
          idx_q <= idx_q + 1'b1;
          if (idx_q == SlotW'(Slots - 1))
            state_q <= act_v_q ? S_FIN : S_SCAN;
        end
        S_SCAN: begin
          if (used_q[idx_q] && en_q[idx_q] && !recent) begin
            if (until_q[idx_q] != '0) begin
              if (!lt) begin
                fired_q <= 1'b1; fire_s_q <= idx_q; until_q[idx_q] <= '0;
              end
            end else if (rep_q[idx_q]) begin
              if (req_q.now_hour == hour_q[idx_q] && req_q.now_minute == min_q[idx_q] &&
                  req_q.now_second == '0) begin
                fired_q <= 1'b1; fire_s_q <= idx_q;
              end
            end else if (due_q[idx_q] != '0 && now >= due_q[idx_q]) begin
              fired_q <= 1'b1; fire_s_q <= idx_q;
            end
          end
          idx_q <= idx_q + 1'b1;
          if (idx_q == SlotW'(Slots - 1) || (used_q[idx_q] && en_q[idx_q] && !recent &&
              ((until_q[idx_q] != '0 && !lt) ||
               (until_q[idx_q] == '0 && rep_q[idx_q] &&
                req_q.now_hour == hour_q[idx_q] && req_q.now_minute == min_q[idx_q] &&
                req_q.now_second == '0) ||
               (until_q[idx_q] == '0 && !rep_q[idx_q] && due_q[idx_q] != '0 &&
                now >= due_q[idx_q]))))
            state_q <= S_FIN;
        end
        S_TS0: begin
          acc_q <= add_y;
          state_q <= S_TS1;
        end
        S_TS1: begin
          acc_q <= add_y;
          state_q <= S_TS2;
        end
        S_TS2: begin
          // signed 34-bit sums: base may be negative, today's match may pass 32 bits
          if ($signed(acc_q) <= $signed({2'b00, now})) ts_q <= sat34(add_y);
          else ts_q <= sat34(acc_q);
          state_q <= S_FIN;
        end
        S_FIN: begin
          added_q <= (req_q.action == ActAdd && free_v) ? free_s : '0;
          unique case (req_q.action)
            ActTick: begin
              status_q <= fired_q ? StRang : StOk;
              if (fired_q) begin
                ring_q[fire_s_q] <= 1'b1;
                last_q[fire_s_q] <= now;
                act_v_q <= 1'b1;
                act_s_q <= fire_s_q;
              end
            end
            ActAdd: begin
              if (!free_v) begin
                status_q <= StFull;
              end else begin
                status_q <= StOk;
                used_q[free_s] <= 1'b1; en_q[free_s] <= 1'b1;
                rep_q[free_s] <= req_q.repeat_daily;
                hour_q[free_s] <= req_q.alarm_hour; min_q[free_s] <= req_q.alarm_minute;
                snz_q[free_s] <= req_q.snooze_minutes; ring_q[free_s] <= 1'b0;
                until_q[free_s] <= '0; last_q[free_s] <= '0;
                due_q[free_s] <= req_q.repeat_daily ? '0 : ts_q;
              end
            end
            ActStop: begin
              if (act_v_q && ring_q[act_s_q]) begin
                if (act_rings) begin
                  status_q <= StOk;
                  ring_q[act_s_q] <= 1'b0;
                  if (!rep_q[act_s_q]) en_q[act_s_q] <= 1'b0;
                  act_v_q <= 1'b0; act_s_q <= '0;
                end else begin
                  status_q <= StNoRing;
                end
              end else if (!used_q[sl]) begin
                status_q <= StEmpty;
              end else begin
                status_q <= StOk;
                en_q[sl] <= !en_q[sl];
                if (!en_q[sl] && !rep_q[sl] && until_q[sl] == '0) due_q[sl] <= ts_q;
                if (en_q[sl]) begin
                  ring_q[sl] <= 1'b0; until_q[sl] <= '0;
                  if (act_v_q && act_s_q == sl) begin
                    act_v_q <= 1'b0; act_s_q <= '0;
                  end
                end
              end
            end
            ActDelete: begin
              if (!used_q[sl]) begin
                status_q <= StEmpty;
              end else begin
                status_q <= StOk;
                used_q[sl] <= 1'b0; en_q[sl] <= 1'b0; rep_q[sl] <= 1'b0;
                hour_q[sl] <= '0; min_q[sl] <= '0; snz_q[sl] <= '0; ring_q[sl] <= 1'b0;
                due_q[sl] <= '0; until_q[sl] <= '0; last_q[sl] <= '0;
                if (act_v_q && act_s_q == sl) begin
                  act_v_q <= 1'b0; act_s_q <= '0;
                end
              end
            end
            ActSnooze: begin
              if (!act_rings) begin
                status_q <= StNoRing;
              end else begin
                status_q <= StOk;
                ring_q[act_s_q] <= 1'b0;
                until_q[act_s_q] <= sat34(add_y);
                last_q[act_s_q] <= now;
                act_v_q <= 1'b0; act_s_q <= '0;
              end
            end
            default: status_q <= StOk;
          endcase
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result flags and counts follow the state after the action
  always_comb begin
    out_data_o.status        = status_q;
    out_data_o.added_slot    = added_q;
    out_data_o.ringing       = act_rings;
    out_data_o.ring_slot     = act_rings ? act_s_q : '0;
    out_data_o.enabled_count = cnt_e;
    out_data_o.used_count    = cnt_u;
  end

  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_ready_i |=> out_valid_o;
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result dropped while stalled");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !(in_ready_o && out_valid_o)) else $error("ready while result pending");

  a_active_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
      act_v_q |-> used_q[act_s_q]) else $error("active slot not in use");

endmodule
`default_nettype wire
